/* rtl/core/bzs_pkg.sv */
package bzs_pkg;

   // segment count per curve (default), clamped to 1..63 in the sequencer
   localparam int BZS_SEGMENTS = 20;

   localparam int BZS_COORD_W = 12;   // control point coordinate, whole pixels
   localparam int BZS_POINT_W = 16;   // sample coordinate, 1/16 pixel
   localparam int BZS_INDEX_W = 6;    // sample index
   localparam int BZS_T_W     = 17;   // t and u, 16 fraction bits, up to 1.0
   localparam int BZS_T3_W    = 18;   // 3*t and 3*u
   localparam int BZS_SQ_W    = 34;   // u^2 and t^2
   localparam int BZS_WGT_W   = 49;   // bernstein weight, up to 2^48
   localparam int BZS_PROD_W  = 60;   // point times weight and sums of them
   localparam int BZS_SHIFT   = 44;   // 48 weight bits less 4 fraction bits

   localparam logic [BZS_T_W-1:0]    BZS_ONE_T = BZS_T_W'(1) << 16;
   localparam logic [BZS_PROD_W-1:0] BZS_ROUND = BZS_PROD_W'(1) << (BZS_SHIFT - 1);

   typedef struct packed {
      logic [BZS_COORD_W-1:0] start_x;
      logic [BZS_COORD_W-1:0] start_y;
      logic [BZS_COORD_W-1:0] ctrl1_x;
      logic [BZS_COORD_W-1:0] ctrl1_y;
      logic [BZS_COORD_W-1:0] ctrl2_x;
      logic [BZS_COORD_W-1:0] ctrl2_y;
      logic [BZS_COORD_W-1:0] end_x;
      logic [BZS_COORD_W-1:0] end_y;
   } req_type;

   typedef struct packed {
      logic [BZS_POINT_W-1:0] point_x;
      logic [BZS_POINT_W-1:0] point_y;
      logic [BZS_INDEX_W-1:0] sample_index;
      logic                   last_sample;
   } rsp_type;

   // stage control that travels with each sample
   typedef struct packed {
      logic                   valid;
      logic [BZS_INDEX_W-1:0] index;
      logic                   last;
   } ctl_type;

   typedef struct packed {
      logic [BZS_WGT_W-1:0] w0;
      logic [BZS_WGT_W-1:0] w1;
      logic [BZS_WGT_W-1:0] w2;
      logic [BZS_WGT_W-1:0] w3;
   } wgt_type;

endpackage

/* rtl/core/bzs_seq.sv */
module bzs_seq #(
   parameter int SEGMENTS = bzs_pkg::BZS_SEGMENTS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  bzs_pkg::req_type                req_data,
   output bzs_pkg::ctl_type                ctl_out,
   output logic [bzs_pkg::BZS_T_W-1:0]     t_out,
   output logic [bzs_pkg::BZS_T_W-1:0]     u_out,
   output bzs_pkg::req_type                pts_out
);
   import bzs_pkg::*;

   localparam int SEG   = (SEGMENTS < 1) ? 1 : ((SEGMENTS > 63) ? 63 : SEGMENTS);
   localparam int STEP  = 65536 / SEG;
   localparam int REM   = 65536 % SEG;
   localparam int R_W   = 6;

   localparam logic [BZS_INDEX_W-1:0] SEG_W = BZS_INDEX_W'(SEG);

   logic                   active_ff, active_in;
   logic [BZS_INDEX_W-1:0] count_ff, count_in;
   logic [BZS_T_W-1:0]     q_ff, q_in;
   logic [R_W-1:0]         r_ff, r_in;
   req_type                pts_ff, pts_in;
   logic [R_W:0]           r_sum;
   logic                   wrap;
   logic                   is_last;
   logic                   take;

   assign is_last   = (count_ff == SEG_W);
   assign req_stall = !en || (active_ff && !is_last);
   assign take      = req_valid && !req_stall;

   // t = round(i*2^16/seg) kept as running quotient and remainder
   assign r_sum = {1'b0, r_ff} + (R_W+1)'(REM);
   assign wrap  = (r_sum >= (R_W+1)'(SEG));

   always_comb begin
      active_in = active_ff;
      count_in  = count_ff;
      q_in      = q_ff;
      r_in      = r_ff;
      pts_in    = pts_ff;
      if (en && active_ff) begin
         count_in = count_ff + 1'b1;
         q_in     = q_ff + BZS_T_W'(STEP) + BZS_T_W'(wrap);
         r_in     = wrap ? R_W'(r_sum - (R_W+1)'(SEG)) : r_sum[R_W-1:0];
         if (is_last) begin
            active_in = 1'b0;
         end
      end
      if (take) begin
         active_in = 1'b1;
         count_in  = '0;
         q_in      = '0;
         r_in      = R_W'(SEG / 2);
         pts_in    = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         active_ff <= active_in;
         count_ff  <= count_in;
      end
      q_ff   <= q_in;
      r_ff   <= r_in;
      pts_ff <= pts_in;
   end

   assign ctl_out.valid = active_ff;
   assign ctl_out.index = count_ff;
   assign ctl_out.last  = is_last;
   assign t_out         = q_ff;
   assign u_out         = BZS_ONE_T - q_ff;
   assign pts_out       = pts_ff;

   a_take_starts: assert property (@(posedge clock) disable iff (reset)
      take |=> active_ff && count_ff == '0)
      else $error("accepted request did not start at sample zero");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> count_ff <= SEG_W)
      else $error("sample counter ran past the segment count");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      active_ff && !en |=> active_ff && $stable(count_ff) && $stable(q_ff))
      else $error("sequencer moved while stalled");

endmodule

/* rtl/core/bzs_weight.sv */
module bzs_weight (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  bzs_pkg::ctl_type            ctl_in,
   input  logic [bzs_pkg::BZS_T_W-1:0] t_in,
   input  logic [bzs_pkg::BZS_T_W-1:0] u_in,
   input  bzs_pkg::req_type            pts_in,
   output bzs_pkg::ctl_type            ctl_out,
   output bzs_pkg::wgt_type            wgt_out,
   output bzs_pkg::req_type            pts_out
);
   import bzs_pkg::*;

   // stage 1: squares and triples
   ctl_type              ctl1_ff;
   logic [BZS_SQ_W-1:0]  uu_ff, uu_in;
   logic [BZS_SQ_W-1:0]  tt_ff, tt_in;
   logic [BZS_T3_W-1:0]  u3_ff, u3_in;
   logic [BZS_T3_W-1:0]  t3_ff, t3_in;
   logic [BZS_T_W-1:0]   u1_ff, t1_ff;
   req_type              pts1_ff;

   // stage 2: weights
   ctl_type              ctl2_ff;
   wgt_type              wgt_ff;
   req_type              pts2_ff;

   logic [BZS_SQ_W+BZS_T_W-1:0]  p0, p3;
   logic [BZS_SQ_W+BZS_T3_W-1:0] p1, p2;

   assign uu_in = u_in * u_in;
   assign tt_in = t_in * t_in;
   assign u3_in = BZS_T3_W'(u_in) + {u_in, 1'b0};
   assign t3_in = BZS_T3_W'(t_in) + {t_in, 1'b0};

   assign p0 = uu_ff * u1_ff;
   assign p1 = uu_ff * t3_ff;
   assign p2 = tt_ff * u3_ff;
   assign p3 = tt_ff * t1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff.valid <= 1'b0;
         ctl2_ff.valid <= 1'b0;
      end else if (en) begin
         ctl1_ff.valid <= ctl_in.valid;
         ctl2_ff.valid <= ctl1_ff.valid;
      end
      if (en) begin
         ctl1_ff.index <= ctl_in.index;
         ctl1_ff.last  <= ctl_in.last;
         uu_ff         <= uu_in;
         tt_ff         <= tt_in;
         u3_ff         <= u3_in;
         t3_ff         <= t3_in;
         u1_ff         <= u_in;
         t1_ff         <= t_in;
         pts1_ff       <= pts_in;
         ctl2_ff.index <= ctl1_ff.index;
         ctl2_ff.last  <= ctl1_ff.last;
         wgt_ff.w0     <= p0[BZS_WGT_W-1:0];
         wgt_ff.w1     <= p1[BZS_WGT_W-1:0];
         wgt_ff.w2     <= p2[BZS_WGT_W-1:0];
         wgt_ff.w3     <= p3[BZS_WGT_W-1:0];
         pts2_ff       <= pts1_ff;
      end
   end

   assign ctl_out = ctl2_ff;
   assign wgt_out = wgt_ff;
   assign pts_out = pts2_ff;

endmodule

/* rtl/core/bzs_blend.sv */
module bzs_blend (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  bzs_pkg::ctl_type ctl_in,
   input  bzs_pkg::wgt_type wgt_in,
   input  bzs_pkg::req_type pts_in,
   output logic             rsp_valid,
   output bzs_pkg::rsp_type rsp_data
);
   import bzs_pkg::*;

   localparam int MUL_W = BZS_COORD_W + BZS_WGT_W;

   // stage 3: point times weight
   ctl_type               ctl3_ff;
   logic [BZS_PROD_W-1:0] px_ff [4];
   logic [BZS_PROD_W-1:0] py_ff [4];
   logic [MUL_W-1:0]      mx [4];
   logic [MUL_W-1:0]      my [4];

   // stage 4: pair sums
   ctl_type               ctl4_ff;
   logic [BZS_PROD_W-1:0] sxa_ff, sxb_ff, sya_ff, syb_ff;

   // stage 5: output register
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff, rsp_in;
   logic [BZS_PROD_W-1:0] tot_x, tot_y;

   assign mx[0] = pts_in.start_x * wgt_in.w0;
   assign mx[1] = pts_in.ctrl1_x * wgt_in.w1;
   assign mx[2] = pts_in.ctrl2_x * wgt_in.w2;
   assign mx[3] = pts_in.end_x   * wgt_in.w3;
   assign my[0] = pts_in.start_y * wgt_in.w0;
   assign my[1] = pts_in.ctrl1_y * wgt_in.w1;
   assign my[2] = pts_in.ctrl2_y * wgt_in.w2;
   assign my[3] = pts_in.end_y   * wgt_in.w3;

   // weights sum to 2^48, so every sum stays below 2^60
   assign tot_x = sxa_ff + sxb_ff + BZS_ROUND;
   assign tot_y = sya_ff + syb_ff + BZS_ROUND;

   always_comb begin
      rsp_in.point_x      = tot_x[BZS_SHIFT +: BZS_POINT_W];
      rsp_in.point_y      = tot_y[BZS_SHIFT +: BZS_POINT_W];
      rsp_in.sample_index = ctl4_ff.index;
      rsp_in.last_sample  = ctl4_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl3_ff.valid <= 1'b0;
         ctl4_ff.valid <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else if (en) begin
         ctl3_ff.valid <= ctl_in.valid;
         ctl4_ff.valid <= ctl3_ff.valid;
         rsp_valid_ff  <= ctl4_ff.valid;
      end
      if (en) begin
         ctl3_ff.index <= ctl_in.index;
         ctl3_ff.last  <= ctl_in.last;
         for (int k = 0; k < 4; k++) begin
            px_ff[k] <= mx[k][BZS_PROD_W-1:0];
            py_ff[k] <= my[k][BZS_PROD_W-1:0];
         end
         ctl4_ff.index <= ctl3_ff.index;
         ctl4_ff.last  <= ctl3_ff.last;
         sxa_ff        <= px_ff[0] + px_ff[1];
         sxb_ff        <= px_ff[2] + px_ff[3];
         sya_ff        <= py_ff[0] + py_ff[1];
         syb_ff        <= py_ff[2] + py_ff[3];
         rsp_ff        <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/core/cubic_bezier_curve_sampler.sv */
// channel   direction  ports                              transfer when
// req       in         req_valid req_stall req_data       req_valid & !req_stall
// rsp       out        rsp_valid rsp_stall rsp_data       rsp_valid & !rsp_stall
//
// each request gives SEGMENTS+1 samples, one per cycle while rsp_stall does
// not hold the pipe; the next request is taken in the cycle that issues the
// last sample of the current one
// a sample passes stage 0, then stages 1 to 5, on its way to rsp
// reset is synchronous and clears the sequencer and the stage valid bits
// rsp_stall with a sample waiting freezes every stage; nothing lost or repeated
module cubic_bezier_curve_sampler #(
   parameter int SEGMENTS = bzs_pkg::BZS_SEGMENTS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bzs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bzs_pkg::rsp_type rsp_data
);
   import bzs_pkg::*;

   // one global advance: the pipe moves unless the output holds a sample
   // that the receiver is stalling
   logic                 en;

   // sequencer -> weight stages
   ctl_type              seq_ctl;
   logic [BZS_T_W-1:0]   seq_t;
   logic [BZS_T_W-1:0]   seq_u;
   req_type              seq_pts;

   // weight stages -> blend stages
   ctl_type              wgt_ctl;
   wgt_type              wgt;
   req_type              wgt_pts;

   assign en = !(rsp_valid && rsp_stall);

   // stage 0: holds the control points and steps i, t and u
   bzs_seq #(
      .SEGMENTS (SEGMENTS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .ctl_out   (seq_ctl),
      .t_out     (seq_t),
      .u_out     (seq_u),
      .pts_out   (seq_pts)
   );

   // stages 1 and 2: squares, then the four bernstein weights
   bzs_weight u_weight (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .ctl_in  (seq_ctl),
      .t_in    (seq_t),
      .u_in    (seq_u),
      .pts_in  (seq_pts),
      .ctl_out (wgt_ctl),
      .wgt_out (wgt),
      .pts_out (wgt_pts)
   );

   // stages 3 to 5: products, pair sums, rounding into the output register
   bzs_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .ctl_in    (wgt_ctl),
      .wgt_in    (wgt),
      .pts_in    (wgt_pts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // end samples carry a single full weight, so they land on whole pixels
   a_endpoints_whole: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.sample_index == '0 || rsp_data.last_sample)
      |-> rsp_data.point_x[3:0] == '0 && rsp_data.point_y[3:0] == '0)
      else $error("curve end sample is not on a whole pixel");

endmodule
